FILE: rtl/p2ci_pkg.sv
// Shared types and constants of the position to cell index block.
// Holds the payload structs, the controller states and the command/status bundles.
// Depends on nothing; every other file of the block imports it.
package p2ci_pkg;

  localparam int unsigned POS_BITS        = 32;
  localparam int unsigned SLOT_BITS       = 10;
  localparam int unsigned CNT_BITS        = 10;
  localparam int unsigned TOL_BITS        = 31;
  localparam int unsigned STAT_BITS       = 2;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 31;
  localparam int unsigned MAX_FACES_DEF   = 1024;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_CELL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLAMP_ENABLE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLAMP_TOL    = 2'd2;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  localparam logic [STAT_BITS-1:0] STAT_FOUND = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_RANGE = 2'd1;

  typedef struct packed {
    logic                       command;
    logic [SLOT_BITS-1:0]       face_slot;
    logic signed [POS_BITS-1:0] face_position;
    logic signed [POS_BITS-1:0] query_position;
    logic                       low_side;
  } p2ci_in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  cell_index;
    logic [STAT_BITS-1:0] status;
  } p2ci_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_CLAMP_LO,
    S_CLAMP_HI,
    S_CHECK,
    S_SEARCH,
    S_FIN,
    S_DONE
  } p2ci_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic set_err;   // cell count unusable: result is out of range
    logic rd_last;   // read the last face
    logic clamp_lo;  // capture last face, clamp toward first face
    logic clamp_hi;  // clamp toward last face
    logic check;     // end checks, start the bisection
    logic step;      // one bisection step
    logic fin;       // resolve the exact-face side
    logic push;      // move the result into the output register
  } p2ci_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic cnt_bad;
    logic hit_first;
    logic hit_last;
    logic out_range;
    logic more_init;
    logic more_step;
    logic out_free;
  } p2ci_sts_t;

endpackage

FILE: rtl/p2ci_ctrl.sv
// Sequencer of the position to cell index block.
// Walks one query through end reads, clamping, end checks and the bisection.
// Depends on p2ci_pkg.
module p2ci_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  p2ci_pkg::p2ci_sts_t sts_i,
  output p2ci_pkg::p2ci_cmd_t cmd_o
);
  import p2ci_pkg::*;

  p2ci_state_e state_q, state_d;
  logic        take;

  assign take = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && sts_i.is_query) begin
          state_d = sts_i.cnt_bad ? S_DONE : S_RD_LAST;
        end
      end
      S_RD_LAST:  state_d = S_CLAMP_LO;
      S_CLAMP_LO: state_d = S_CLAMP_HI;
      S_CLAMP_HI: state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.hit_first || sts_i.hit_last || sts_i.out_range) begin
          state_d = S_DONE;
        end else if (sts_i.more_init) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SEARCH: begin
        if (!sts_i.more_step) begin
          state_d = S_FIN;
        end
      end
      S_FIN: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.take     = take;
    cmd_o.set_err  = take && sts_i.is_query && sts_i.cnt_bad;
    cmd_o.rd_last  = (state_q == S_RD_LAST);
    cmd_o.clamp_lo = (state_q == S_CLAMP_LO);
    cmd_o.clamp_hi = (state_q == S_CLAMP_HI);
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.step     = (state_q == S_SEARCH);
    cmd_o.fin      = (state_q == S_FIN);
    cmd_o.push     = (state_q == S_DONE) && sts_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: rtl/p2ci_dpath.sv
// Datapath of the position to cell index block: configuration registers,
// face memory, query and bracket registers, result and output register.
// Depends on p2ci_pkg.
module p2ci_dpath #(
  parameter int unsigned MAX_FACES = p2ci_pkg::MAX_FACES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [p2ci_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [p2ci_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  p2ci_pkg::p2ci_in_t                  in_data_i,
  input  p2ci_pkg::p2ci_cmd_t                 cmd_i,
  output p2ci_pkg::p2ci_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output p2ci_pkg::p2ci_out_t                 out_data_o
);
  import p2ci_pkg::*;

  localparam int unsigned AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

  // Configuration
  logic [CNT_BITS-1:0] cell_count_q;
  logic                clamp_en_q;
  logic [TOL_BITS-1:0] clamp_tol_q;

  // Face memory
  logic signed [POS_BITS-1:0] face_mem [MAX_FACES];
  logic signed [POS_BITS-1:0] rdata_q;
  logic [AW-1:0]              raddr;
  logic                       slot_ok;

  // Query state
  logic signed [POS_BITS-1:0] q_q, first_q, last_q;
  logic                       low_q;
  logic [AW-1:0]              lo_q, hi_q, mid_q;
  logic [AW-1:0]              lo_n, hi_n, diff_n, n_a, lo_adj;
  logic [AW:0]                sum_n;
  logic                       ge;

  logic [CNT_BITS-1:0]  res_idx_q;
  logic [STAT_BITS-1:0] res_st_q;
  logic                 out_valid_q;
  p2ci_out_t            out_q;

  logic [POS_BITS:0] d_lo, d_hi, tol_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CNT_BITS'(1);
      clamp_en_q   <= 1'b0;
      clamp_tol_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CELL_COUNT:   cell_count_q <= cfg_wdata_i[CNT_BITS-1:0];
        REG_CLAMP_ENABLE: clamp_en_q   <= cfg_wdata_i[0];
        REG_CLAMP_TOL:    clamp_tol_q  <= cfg_wdata_i[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign n_a     = AW'(cell_count_q);
  assign slot_ok = 32'(in_data_i.face_slot) < 32'(MAX_FACES);

  // Bisection step: face[mid] sits in rdata_q
  assign ge     = (rdata_q <= q_q);
  assign lo_n   = ge ? mid_q : lo_q;
  assign hi_n   = ge ? hi_q : mid_q;
  assign diff_n = hi_n - lo_n;
  assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  assign lo_adj = lo_q - AW'(1);

  always_comb begin
    raddr = '0;
    if (cmd_i.rd_last) begin
      raddr = n_a;
    end else if (cmd_i.check) begin
      raddr = sts_o.more_init ? (n_a >> 1) : '0;
    end else if (cmd_i.step) begin
      raddr = sts_o.more_step ? sum_n[AW:1] : lo_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.command == CMD_LOAD && slot_ok) begin
      face_mem[AW'(in_data_i.face_slot)] <= in_data_i.face_position;
    end
    rdata_q <= face_mem[raddr];
  end

  // Overshoot distances, both positive when the matching compare holds
  assign d_lo  = {first_q[POS_BITS-1], first_q} - {q_q[POS_BITS-1], q_q};
  assign d_hi  = {q_q[POS_BITS-1], q_q} - {last_q[POS_BITS-1], last_q};
  assign tol_x = (POS_BITS+1)'(clamp_tol_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      q_q   <= in_data_i.query_position;
      low_q <= in_data_i.low_side;
    end
    if (cmd_i.rd_last) begin
      first_q <= rdata_q;
    end
    if (cmd_i.clamp_lo) begin
      last_q <= rdata_q;
      if (clamp_en_q && (q_q < first_q) && (d_lo < tol_x)) begin
        q_q <= first_q;
      end
    end
    if (cmd_i.clamp_hi) begin
      if (clamp_en_q && (q_q > last_q) && (d_hi < tol_x)) begin
        q_q <= last_q;
      end
    end
    if (cmd_i.check) begin
      lo_q  <= '0;
      hi_q  <= n_a;
      mid_q <= n_a >> 1;
    end
    if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= sum_n[AW:1];
    end
    // Result
    if (cmd_i.set_err) begin
      res_idx_q <= '0;
      res_st_q  <= STAT_RANGE;
    end
    if (cmd_i.check) begin
      if (sts_o.hit_first) begin
        res_idx_q <= '0;
        res_st_q  <= STAT_FOUND;
      end else if (sts_o.hit_last) begin
        res_idx_q <= cell_count_q - CNT_BITS'(1);
        res_st_q  <= STAT_FOUND;
      end else begin
        res_idx_q <= '0;
        res_st_q  <= STAT_RANGE;
      end
    end
    if (cmd_i.fin) begin
      res_st_q <= STAT_FOUND;
      if ((q_q == rdata_q) && !low_q && (lo_q != '0)) begin
        res_idx_q <= CNT_BITS'(lo_adj);
      end else begin
        res_idx_q <= CNT_BITS'(lo_q);
      end
    end
    if (cmd_i.push) begin
      out_q.cell_index <= res_idx_q;
      out_q.status     <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_query  = (in_data_i.command == CMD_QUERY);
    sts_o.cnt_bad   = (cell_count_q == '0) || (32'(cell_count_q) >= 32'(MAX_FACES));
    sts_o.hit_first = (q_q == first_q);
    sts_o.hit_last  = (q_q == last_q);
    sts_o.out_range = (q_q < first_q) || (q_q > last_q);
    sts_o.more_init = (n_a > AW'(1));
    sts_o.more_step = (diff_n > AW'(1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/position_to_cell_index_core.sv
// Top level of the position to cell index block: sequencer plus datapath.
// Depends on p2ci_pkg, p2ci_ctrl and p2ci_dpath.
//
//   channel   direction  handshake            beat
//   in        input      in_valid/in_ready    p2ci_in_t: load a face or query a position
//   out       output     out_valid/out_ready  p2ci_out_t: cell index and status
//   cfg       input      cfg_we (no wait)     register index and write data
//
// A load is written to the face memory on acceptance and gives no result. A query
// runs one item at a time: accept, read last face, a low and a high clamp step, end
// checks, the bisection steps and a side-resolve step, then the result enters the
// output register. A query that lands on an end or outside the line skips the
// bisection and side-resolve steps; a cell count of zero or of MAX_FACES or more
// goes straight to an out-of-range result. The face memory has a single read port
// (one face per cycle), so the faces are read one at a time.
// Reset sets the configuration registers to cell_count 1, clamping off, tolerance 0; the face
// memory is not cleared and a face slot must be loaded before a query reads it.
// A stalled output holds its beat; the block accepts the next beat meanwhile and
// holds a finished query until the output register frees.
module position_to_cell_index_core #(
  parameter int unsigned MAX_FACES = p2ci_pkg::MAX_FACES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [p2ci_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [p2ci_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  p2ci_pkg::p2ci_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output p2ci_pkg::p2ci_out_t                 out_data_o
);
  import p2ci_pkg::*;

  p2ci_cmd_t cmd;
  p2ci_sts_t sts;

  // Sequence each query; loads pass straight to the memory on acceptance
  p2ci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the face table, the bracket registers and the output beat
  p2ci_dpath #(
    .MAX_FACES (MAX_FACES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
